/* design/isb_pkg.sv */
// isb_pkg: shared types and constants of the imu segment buffer
// holds widths, the sample layout, command and status codes
// no dependencies
package isb_pkg;

  localparam int unsigned DepthDef = 32;
  localparam int unsigned TsW      = 48;
  localparam int unsigned AxW      = 16;
  localparam int unsigned NumAx    = 6;
  localparam int unsigned SegW     = 32;
  localparam int unsigned CapW     = 6;
  localparam int unsigned GapW     = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatW    = 4;
  localparam int unsigned QuoW     = 16;
  localparam int unsigned ProdW    = TsW + QuoW;
  localparam logic [CapW-1:0] CapRst = CapW'(32);
  localparam logic [GapW-1:0] GapRst = GapW'(50000);

  // axis 0..2 acceleration x/y/z, axis 3..5 angular rate x/y/z
  typedef logic [NumAx-1:0][AxW-1:0] axes_t;

  typedef struct packed {
    logic [TsW-1:0] stamp;
    axes_t          ax;
  } sample_t;

  typedef struct packed {
    logic           start;
    logic [TsW-1:0] off;
    logic [TsW-1:0] dur;
  } lerp_req_t;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_ACCEPTED   = 4'd0,
    ST_EVICTED    = 4'd1,
    ST_DUPLICATE  = 4'd2,
    ST_REVERSAL   = 4'd3,
    ST_GAP        = 4'd4,
    ST_READY      = 4'd5,
    ST_INVALID    = 4'd6,
    ST_WAITING    = 4'd7,
    ST_GONE       = 4'd8,
    ST_RESET_DONE = 4'd9
  } status_e;

  typedef struct packed {
    status_e         status;
    logic [TsW-1:0]  stamp;
    axes_t           ax;
    logic [SegW-1:0] seg;
    logic            last;
  } out_t;

endpackage

/* design/isb_ram.sv */
// isb_ram: generic single write port, single read port ram
// read data registered; no dependencies
module isb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/isb_lerp.sv */
// isb_lerp: six-lane linear interpolation, before + off*(after-before)/dur
// split multiply, low half then high half, then a bit-serial restoring divider; uses isb_pkg
module isb_lerp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isb_pkg::lerp_req_t req_i,
  input  isb_pkg::axes_t     before_i,
  input  isb_pkg::axes_t     after_i,
  output logic               done_o,
  output isb_pkg::axes_t     res_o
);

  localparam int unsigned HalfW = isb_pkg::TsW / 2;
  localparam int unsigned PlW   = isb_pkg::AxW + HalfW;
  localparam int unsigned CntW  = $clog2(isb_pkg::QuoW);
  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MLO  = 2'd1;
  localparam logic [1:0] L_MHI  = 2'd2;
  localparam logic [1:0] L_DIV  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  logic [isb_pkg::NumAx-1:0]                     neg_q, neg_d;
  isb_pkg::axes_t                                mag_q, mag_d, base_q, base_d, quo_q, quo_d;
  logic [isb_pkg::NumAx-1:0][PlW-1:0]            plo_q, plo_d;
  logic [isb_pkg::NumAx-1:0][isb_pkg::TsW-1:0]   rem_q, rem_d;
  logic [isb_pkg::TsW-1:0]                       off_q, off_d, dur_q, dur_d;

  always_comb begin
    logic [isb_pkg::AxW:0]       diff;
    logic [isb_pkg::ProdW-1:0]   full;
    logic [isb_pkg::TsW:0]       trial;
    logic                        ge;
    diff    = '0;
    full    = '0;
    trial   = '0;
    ge      = 1'b0;
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    mag_d   = mag_q;
    base_d  = base_q;
    quo_d   = quo_q;
    plo_d   = plo_q;
    rem_d   = rem_q;
    off_d   = off_q;
    dur_d   = dur_q;
    unique case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          off_d   = req_i.off;
          dur_d   = req_i.dur;
          base_d  = before_i;
          state_d = L_MLO;
          for (int l = 0; l < isb_pkg::NumAx; l++) begin
            diff = {after_i[l][isb_pkg::AxW-1], after_i[l]}
                 - {before_i[l][isb_pkg::AxW-1], before_i[l]};
            neg_d[l] = diff[isb_pkg::AxW];
            mag_d[l] = diff[isb_pkg::AxW] ? isb_pkg::AxW'(-diff) : diff[isb_pkg::AxW-1:0];
          end
        end
      end
      L_MLO: begin
        for (int l = 0; l < isb_pkg::NumAx; l++) begin
          plo_d[l] = PlW'(mag_q[l]) * PlW'(off_q[HalfW-1:0]);
        end
        state_d = L_MHI;
      end
      L_MHI: begin
        // quotient fits in QuoW bits since off < dur
        for (int l = 0; l < isb_pkg::NumAx; l++) begin
          full = isb_pkg::ProdW'(plo_q[l])
               + (isb_pkg::ProdW'(PlW'(mag_q[l]) * PlW'(off_q[isb_pkg::TsW-1:HalfW]))
                  << HalfW);
          rem_d[l] = full[isb_pkg::ProdW-1:isb_pkg::QuoW];
          quo_d[l] = full[isb_pkg::QuoW-1:0];
        end
        cnt_d   = '0;
        state_d = L_DIV;
      end
      L_DIV: begin
        for (int l = 0; l < isb_pkg::NumAx; l++) begin
          trial = {rem_q[l], quo_q[l][isb_pkg::QuoW-1]};
          ge    = trial >= {1'b0, dur_q};
          rem_d[l] = ge ? isb_pkg::TsW'(trial - {1'b0, dur_q}) : trial[isb_pkg::TsW-1:0];
          quo_d[l] = {quo_q[l][isb_pkg::QuoW-2:0], ge};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(isb_pkg::QuoW - 1)) begin
          state_d = L_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    base_q <= base_d;
    quo_q  <= quo_d;
    plo_q  <= plo_d;
    rem_q  <= rem_d;
    off_q  <= off_d;
    dur_q  <= dur_d;
  end

  always_comb begin
    for (int l = 0; l < isb_pkg::NumAx; l++) begin
      res_o[l] = neg_q[l] ? base_q[l] - quo_q[l] : base_q[l] + quo_q[l];
    end
  end

  assign done_o = done_q;

endmodule

/* design/imu_segment_buffer_unit.sv */
// imu_segment_buffer_unit: top level of the imu segment buffer
// uses isb_pkg, isb_ram (sample ring) and isb_lerp (interpolation)
//
// A ring of up to DEPTH timestamped imu samples in one ram of stamp plus six
// axes, read one entry per cycle with registered read data. One item is worked
// at a time. An add goes through dispatch, read of the newest stamp, decide
// and write back, to the result; an add to an empty ring writes at dispatch. A
// select reads the newest and oldest stamps, then walks the ring from the
// oldest entry (check, fetch, load per entry) up to the one that reaches the
// interval end; each interpolated endpoint adds a split multiply and a 16-step
// serial divider. A result waits in an output register; the next item is taken
// once the previous one has handed its last result to that register. The
// stores are undefined after reset and need no clearing pass; the fill count
// guards them. The user must write capacity and max_gap only while the block
// is idle; the block does not enforce it.
module imu_segment_buffer_unit #(
  parameter int unsigned DEPTH = isb_pkg::DepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [isb_pkg::GapW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [isb_pkg::CmdW-1:0]        cmd_i,
  input  logic [isb_pkg::TsW-1:0]         stamp_i,
  input  logic [isb_pkg::TsW-1:0]         end_stamp_i,
  input  logic signed [isb_pkg::AxW-1:0]  accel_x_i,
  input  logic signed [isb_pkg::AxW-1:0]  accel_y_i,
  input  logic signed [isb_pkg::AxW-1:0]  accel_z_i,
  input  logic signed [isb_pkg::AxW-1:0]  gyro_x_i,
  input  logic signed [isb_pkg::AxW-1:0]  gyro_y_i,
  input  logic signed [isb_pkg::AxW-1:0]  gyro_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [isb_pkg::StatW-1:0]       status_o,
  output logic [isb_pkg::TsW-1:0]         out_stamp_o,
  output logic signed [isb_pkg::AxW-1:0]  out_accel_x_o,
  output logic signed [isb_pkg::AxW-1:0]  out_accel_y_o,
  output logic signed [isb_pkg::AxW-1:0]  out_accel_z_o,
  output logic signed [isb_pkg::AxW-1:0]  out_gyro_x_o,
  output logic signed [isb_pkg::AxW-1:0]  out_gyro_y_o,
  output logic signed [isb_pkg::AxW-1:0]  out_gyro_z_o,
  output logic [isb_pkg::SegW-1:0]        segment_number_o,
  output logic                            last_o
);

  localparam int unsigned IdxW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SmpW = $bits(isb_pkg::sample_t);
  localparam int unsigned CapCmpW = isb_pkg::CapW + 1;

  // state codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_SELN  = 4'd3;
  localparam logic [3:0] S_SELO  = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_LERP  = 4'd8;
  localparam logic [3:0] S_LEMIT = 4'd9;
  localparam logic [3:0] S_EMIT1 = 4'd10;

  // ring position of entry ofs counted from the oldest
  function automatic logic [IdxW-1:0] wrap_idx(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] ofs);
    logic [CntW:0] sum;
    sum = (CntW+1)'(base) + (CntW+1)'(ofs);
    if (sum >= (CntW+1)'(DEPTH)) sum = sum - (CntW+1)'(DEPTH);
    return sum[IdxW-1:0];
  endfunction

  logic [3:0]                state_q, state_d;
  logic [IdxW-1:0]           oldest_q, oldest_d;
  logic [CntW-1:0]           fill_q, fill_d;
  logic [isb_pkg::SegW-1:0]  seg_q, seg_d;
  logic [isb_pkg::CapW-1:0]  cap_q;
  logic [isb_pkg::GapW-1:0]  gap_q;
  logic                      ov_q;
  logic                      start_done_q, start_done_d;
  logic                      mid_done_q, mid_done_d;

  // item and walk payload
  isb_pkg::cmd_e             cmd_q;
  logic [isb_pkg::TsW-1:0]   t_q, te_q, newest_q, newest_d;
  isb_pkg::axes_t            smp_q;
  logic [CntW-1:0]           k_q, k_d;
  isb_pkg::sample_t          cur_q, cur_d, prev_q, prev_d;
  isb_pkg::status_e          stat_q, stat_d;
  isb_pkg::out_t             out_q;

  // ram port
  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr, ram_raddr;
  isb_pkg::sample_t          ram_wdata, ram_rdata;

  // lerp unit
  isb_pkg::lerp_req_t        lreq;
  logic                      lerp_done;
  isb_pkg::axes_t            lerp_res;

  logic                      in_acc, can_emit, emit_en;
  isb_pkg::out_t             emit_item;
  logic [CapCmpW-1:0]        cap_eff;
  logic                      full_ring;
  logic [isb_pkg::TsW-1:0]   step;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign can_emit   = !ov_q || out_ready_i;

  // capacity 0 behaves as 1, anything above DEPTH as DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CapCmpW'(1);
    end else if (CapCmpW'(cap_q) > CapCmpW'(DEPTH)) begin
      cap_eff = CapCmpW'(DEPTH);
    end else begin
      cap_eff = CapCmpW'(cap_q);
    end
  end
  assign full_ring = CapCmpW'(fill_q) >= cap_eff;
  assign step      = t_q - ram_rdata.stamp;

  always_comb begin
    state_d      = state_q;
    oldest_d     = oldest_q;
    fill_d       = fill_q;
    seg_d        = seg_q;
    start_done_d = start_done_q;
    mid_done_d   = mid_done_q;
    newest_d     = newest_q;
    k_d          = k_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    stat_d       = stat_q;
    ram_we       = 1'b0;
    ram_waddr    = wrap_idx(oldest_q, fill_q);
    ram_wdata    = '{stamp: t_q, ax: smp_q};
    ram_raddr    = wrap_idx(oldest_q, k_q);
    lreq         = '{start: 1'b0, off: t_q - prev_q.stamp, dur: cur_q.stamp - prev_q.stamp};
    emit_en      = 1'b0;
    emit_item    = '{status: isb_pkg::ST_READY, stamp: t_q, ax: cur_q.ax, seg: seg_q,
                     last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DISP;
      end
      S_DISP: begin
        unique case (cmd_q)
          isb_pkg::CMD_ADD: begin
            if (fill_q == '0) begin
              // empty ring: plain append
              ram_we  = 1'b1;
              fill_d  = fill_q + CntW'(1);
              stat_d  = isb_pkg::ST_ACCEPTED;
              state_d = S_EMIT1;
            end else begin
              ram_raddr = wrap_idx(oldest_q, fill_q - CntW'(1));
              state_d   = S_ADDR;
            end
          end
          isb_pkg::CMD_SELECT: begin
            if (te_q <= t_q) begin
              stat_d  = isb_pkg::ST_INVALID;
              state_d = S_EMIT1;
            end else if (fill_q == '0) begin
              stat_d  = isb_pkg::ST_WAITING;
              state_d = S_EMIT1;
            end else begin
              ram_raddr = wrap_idx(oldest_q, fill_q - CntW'(1));
              state_d   = S_SELN;
            end
          end
          isb_pkg::CMD_RESET: begin
            oldest_d = '0;
            fill_d   = '0;
            seg_d    = seg_q + isb_pkg::SegW'(1);
            stat_d   = isb_pkg::ST_RESET_DONE;
            state_d  = S_EMIT1;
          end
          default: begin
            stat_d  = isb_pkg::ST_INVALID;
            state_d = S_EMIT1;
          end
        endcase
      end
      S_ADDR: begin
        // read data holds the newest stored sample
        state_d = S_EMIT1;
        if (t_q == ram_rdata.stamp) begin
          stat_d = isb_pkg::ST_DUPLICATE;
        end else if (t_q < ram_rdata.stamp || step > isb_pkg::TsW'(gap_q)) begin
          // new segment, sample kept as the only entry
          stat_d    = (t_q < ram_rdata.stamp) ? isb_pkg::ST_REVERSAL : isb_pkg::ST_GAP;
          oldest_d  = '0;
          fill_d    = CntW'(1);
          seg_d     = seg_q + isb_pkg::SegW'(1);
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else if (full_ring) begin
          stat_d   = isb_pkg::ST_EVICTED;
          oldest_d = wrap_idx(oldest_q, CntW'(1));
          ram_we   = 1'b1;
        end else begin
          stat_d = isb_pkg::ST_ACCEPTED;
          fill_d = fill_q + CntW'(1);
          ram_we = 1'b1;
        end
      end
      S_SELN: begin
        newest_d  = ram_rdata.stamp;
        ram_raddr = oldest_q;
        state_d   = S_SELO;
      end
      S_SELO: begin
        // read data holds the oldest sample; t <= te is known
        if (t_q > newest_q) begin
          stat_d  = isb_pkg::ST_WAITING;
          state_d = S_EMIT1;
        end else if (t_q < ram_rdata.stamp) begin
          stat_d  = isb_pkg::ST_GONE;
          state_d = S_EMIT1;
        end else if (te_q > newest_q) begin
          stat_d  = isb_pkg::ST_WAITING;
          state_d = S_EMIT1;
        end else begin
          cur_d        = ram_rdata;
          k_d          = '0;
          start_done_d = 1'b0;
          mid_done_d   = 1'b0;
          state_d      = S_CHK;
        end
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cur_d   = ram_rdata;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!start_done_q && cur_q.stamp >= t_q) begin
          // first entry at or past the interval start
          if (cur_q.stamp == t_q || k_q == '0) begin
            if (can_emit) begin
              emit_en      = 1'b1;
              start_done_d = 1'b1;
            end
          end else begin
            lreq.start = 1'b1;
            state_d    = S_LERP;
          end
        end else if (start_done_q && cur_q.stamp > t_q && cur_q.stamp < te_q
                     && !mid_done_q) begin
          // stored sample strictly inside
          if (can_emit) begin
            emit_en         = 1'b1;
            emit_item.stamp = cur_q.stamp;
            mid_done_d      = 1'b1;
          end
        end else if (start_done_q && cur_q.stamp >= te_q) begin
          if (cur_q.stamp == te_q || k_q == '0) begin
            if (can_emit) begin
              emit_en         = 1'b1;
              emit_item.stamp = te_q;
              emit_item.last  = 1'b1;
              state_d         = S_IDLE;
            end
          end else begin
            lreq.start = 1'b1;
            lreq.off   = te_q - prev_q.stamp;
            state_d    = S_LERP;
          end
        end else begin
          prev_d     = cur_q;
          k_d        = k_q + CntW'(1);
          mid_done_d = 1'b0;
          ram_raddr  = wrap_idx(oldest_q, k_q + CntW'(1));
          state_d    = S_FETCH;
        end
      end
      S_LERP: begin
        if (lerp_done) state_d = S_LEMIT;
      end
      S_LEMIT: begin
        if (can_emit) begin
          emit_en      = 1'b1;
          emit_item.ax = lerp_res;
          if (start_done_q) begin
            emit_item.stamp = te_q;
            emit_item.last  = 1'b1;
            state_d         = S_IDLE;
          end else begin
            start_done_d = 1'b1;
            state_d      = S_CHK;
          end
        end
      end
      S_EMIT1: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          emit_item = '{status: stat_q, stamp: '0, ax: '0, seg: seg_q, last: 1'b1};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      oldest_q     <= '0;
      fill_q       <= '0;
      seg_q        <= '0;
      cap_q        <= isb_pkg::CapRst;
      gap_q        <= isb_pkg::GapRst;
      ov_q         <= 1'b0;
      start_done_q <= 1'b0;
      mid_done_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      oldest_q     <= oldest_d;
      fill_q       <= fill_d;
      seg_q        <= seg_d;
      start_done_q <= start_done_d;
      mid_done_q   <= mid_done_d;
      if (emit_en) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i) begin
          gap_q <= cfg_data_i;
        end else begin
          cap_q <= cfg_data_i[isb_pkg::CapW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= isb_pkg::cmd_e'(cmd_i);
      t_q   <= stamp_i;
      te_q  <= end_stamp_i;
      smp_q <= {gyro_z_i, gyro_y_i, gyro_x_i, accel_z_i, accel_y_i, accel_x_i};
    end
    newest_q <= newest_d;
    k_q      <= k_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    stat_q   <= stat_d;
    if (emit_en) out_q <= emit_item;
  end

  isb_ram #(
    .WIDTH(SmpW),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  isb_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (lreq),
    .before_i(prev_q.ax),
    .after_i (cur_q.ax),
    .done_o  (lerp_done),
    .res_o   (lerp_res)
  );

  assign out_valid_o      = ov_q;
  assign status_o         = out_q.status;
  assign out_stamp_o      = out_q.stamp;
  assign out_accel_x_o    = out_q.ax[0];
  assign out_accel_y_o    = out_q.ax[1];
  assign out_accel_z_o    = out_q.ax[2];
  assign out_gyro_x_o     = out_q.ax[3];
  assign out_gyro_y_o     = out_q.ax[4];
  assign out_gyro_z_o     = out_q.ax[5];
  assign segment_number_o = out_q.seg;
  assign last_o           = out_q.last;

  // ring bookkeeping stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DEPTH) && CntW'(oldest_q) < CntW'(DEPTH))
    else $error("ring pointer out of range");

  // a select never writes the ring in its oldest-read, check and interpolation states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK || state_q == S_SELO || state_q == S_LERP) |-> !ram_we)
    else $error("ring written during select walk");

  // interpolation results arrive only while waiting for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lerp_done |-> state_q == S_LERP)
    else $error("unexpected interpolation result");

  // reset command empties the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP && cmd_q == isb_pkg::CMD_RESET) |=> fill_q == '0 && oldest_q == '0)
    else $error("reset command left entries");

endmodule

/* tb/tb_imu_segment_buffer_unit.sv */
// tb_imu_segment_buffer_unit: self-checking bench of the imu segment buffer
// drives adds, selects and resets through a directed table, then random phases
// with several capacity and max_gap settings; depends on isb_pkg and the rtl
module tb_imu_segment_buffer_unit;
  import isb_pkg::*;

  localparam int unsigned RingDepth  = 32;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCyc  = 60;
  localparam int unsigned HoldCyc    = 400;

  // register indexes of the config port
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_MAX_GAP  = 1'b1;

  typedef struct {
    cmd_e           cmd;
    logic [TsW-1:0] stamp;
    logic [TsW-1:0] end_stamp;
    axes_t          ax;
    bit             typed;
    status_e        typed_status;
  } imu_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [GapW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CmdW-1:0] cmd_i = '0;
  logic [TsW-1:0] stamp_i = '0;
  logic [TsW-1:0] end_stamp_i = '0;
  logic signed [AxW-1:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [AxW-1:0] gyro_x_i = '0, gyro_y_i = '0, gyro_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [StatW-1:0] status_o;
  logic [TsW-1:0] out_stamp_o;
  logic signed [AxW-1:0] out_accel_x_o, out_accel_y_o, out_accel_z_o;
  logic signed [AxW-1:0] out_gyro_x_o, out_gyro_y_o, out_gyro_z_o;
  logic [SegW-1:0] segment_number_o;
  logic last_o;

  imu_segment_buffer_unit dut (.*);

  // clock, period 4
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state: sample ring, pointers, segment counter, registers
  logic [TsW-1:0]  ring_stamp [RingDepth];
  axes_t           ring_ax [RingDepth];
  int unsigned     ring_oldest;
  int unsigned     ring_fill;
  logic [SegW-1:0] seg_count;
  logic [CapW-1:0] cap_reg;
  logic [GapW-1:0] gap_reg;

  out_t        result_q[$];
  int unsigned errors;
  int unsigned mismatches;
  int unsigned cycles;
  bit          hold_req;

  function automatic int unsigned ring_slot(int unsigned k);
    return (ring_oldest + k) % RingDepth;
  endfunction

  function automatic logic [TsW-1:0] newest_stamp();
    return ring_stamp[ring_slot(ring_fill - 1)];
  endfunction

  function automatic out_t make_result(status_e st, logic [TsW-1:0] ts, axes_t ax,
                                       logic lst);
    out_t r;
    r.status = st;
    r.stamp  = ts;
    r.ax     = ax;
    r.seg    = seg_count;
    r.last   = lst;
    return r;
  endfunction

  // append one expected result
  function automatic void queue_result(out_t r);
    result_q = {result_q, r};
  endfunction

  // linear blend of one axis, truncated toward zero, 64-bit product as in hw
  function automatic logic [AxW-1:0] blend(logic [AxW-1:0] vb, logic [AxW-1:0] va,
                                           logic [63:0] off, logic [63:0] dur);
    int b, a, d, r;
    logic [63:0] mag, q;
    b = int'($signed(vb));
    a = int'($signed(va));
    d = a - b;
    mag = (d < 0) ? 64'(-longint'(d)) : 64'(d);
    q = (mag * off) / dur;
    r = (d < 0) ? b - int'(q[31:0]) : b + int'(q[31:0]);
    return r[AxW-1:0];
  endfunction

  // sample at time t, which lies inside the stored span
  function automatic axes_t sample_at(logic [TsW-1:0] t);
    int unsigned k, pa, pb;
    axes_t r;
    k = 0;
    while (k < ring_fill && ring_stamp[ring_slot(k)] < t) k++;
    if (k >= ring_fill) k = ring_fill - 1;
    pa = ring_slot(k);
    if (k == 0 || ring_stamp[pa] == t) return ring_ax[pa];
    pb = ring_slot(k - 1);
    for (int i = 0; i < NumAx; i++)
      r[i] = blend(ring_ax[pb][i], ring_ax[pa][i], 64'(t - ring_stamp[pb]),
                   64'(ring_stamp[pa] - ring_stamp[pb]));
    return r;
  endfunction

  function automatic status_e cover_status(logic [TsW-1:0] t);
    if (ring_fill == 0 || t > newest_stamp()) return ST_WAITING;
    if (t < ring_stamp[ring_slot(0)]) return ST_GONE;
    return ST_READY;
  endfunction

  function automatic void store_sample(logic [TsW-1:0] t, axes_t ax);
    int unsigned p;
    p = ring_slot(ring_fill);
    ring_stamp[p] = t;
    ring_ax[p] = ax;
    ring_fill++;
  endfunction

  // work out the results of one accepted item and queue them
  function automatic void predict_segment(imu_item_t it);
    int unsigned cap;
    status_e st;
    logic [TsW-1:0] nw;
    case (it.cmd)
      CMD_ADD: begin
        cap = cap_reg;
        if (cap < 1) cap = 1;
        if (cap > RingDepth) cap = RingDepth;
        st = ST_ACCEPTED;
        if (ring_fill > 0) begin
          nw = newest_stamp();
          if (it.stamp == nw) begin
            queue_result(make_result(ST_DUPLICATE, '0, '0, 1'b1));
            return;
          end
          if (it.stamp < nw || it.stamp - nw > TsW'(gap_reg)) begin
            st = (it.stamp < nw) ? ST_REVERSAL : ST_GAP;
            ring_oldest = 0;
            ring_fill = 0;
            seg_count++;
            store_sample(it.stamp, it.ax);
            queue_result(make_result(st, '0, '0, 1'b1));
            return;
          end
        end
        if (ring_fill >= cap) begin
          ring_oldest = ring_slot(1);
          ring_fill--;
          st = ST_EVICTED;
        end
        store_sample(it.stamp, it.ax);
        queue_result(make_result(st, '0, '0, 1'b1));
      end
      CMD_SELECT: begin
        if (it.end_stamp <= it.stamp) begin
          queue_result(make_result(ST_INVALID, '0, '0, 1'b1));
          return;
        end
        st = cover_status(it.stamp);
        if (st == ST_READY) st = cover_status(it.end_stamp);
        if (st != ST_READY) begin
          queue_result(make_result(st, '0, '0, 1'b1));
          return;
        end
        queue_result(make_result(ST_READY, it.stamp, sample_at(it.stamp), 1'b0));
        for (int unsigned k = 0; k < ring_fill; k++) begin
          if (ring_stamp[ring_slot(k)] > it.stamp && ring_stamp[ring_slot(k)] < it.end_stamp)
            queue_result(make_result(ST_READY, ring_stamp[ring_slot(k)],
                                     ring_ax[ring_slot(k)], 1'b0));
        end
        queue_result(make_result(ST_READY, it.end_stamp, sample_at(it.end_stamp), 1'b1));
      end
      CMD_RESET: begin
        ring_oldest = 0;
        ring_fill = 0;
        seg_count++;
        queue_result(make_result(ST_RESET_DONE, '0, '0, 1'b1));
      end
      default: queue_result(make_result(ST_INVALID, '0, '0, 1'b1));
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic axes_t rand_axes();
    axes_t ax;
    for (int i = 0; i < NumAx; i++) ax[i] = AxW'($urandom);
    return ax;
  endfunction

  function automatic logic [TsW-1:0] rand_below(logic [TsW-1:0] span);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return TsW'(r % (64'(span) + 64'd1));
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, long hold-off on request, check at negedge
  initial begin
    int unsigned idle;
    bit hold_done;
    out_t got, want;
    idle = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.status = status_e'(status_o);
        got.stamp  = out_stamp_o;
        got.ax     = {out_gyro_z_o, out_gyro_y_o, out_gyro_x_o,
                      out_accel_z_o, out_accel_y_o, out_accel_x_o};
        got.seg    = segment_number_o;
        got.last   = last_o;
        if (result_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result status %0d", got.status);
        end else begin
          want = result_q[0];
          result_q.delete(0);
          if (got !== want) begin
            errors++;
            if (mismatches++ < 10) begin
              $display("mismatch: exp st %0d ts %h ax %h seg %0d last %b",
                       want.status, want.stamp, want.ax, want.seg, want.last);
              $display("          got st %0d ts %h ax %h seg %0d last %b",
                       got.status, got.stamp, got.ax, got.seg, got.last);
            end
          end
        end
      end
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        // long hold-off counted here while the sender keeps going
        out_ready_i <= 1'b0;
        hold_done = 1'b1;
        repeat (HoldCyc) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle > 0) begin
        idle--;
        out_ready_i <= 1'b0;
      end else begin
        idle = gap_len();
        out_ready_i <= (idle == 0);
      end
    end
  end

  // offer one item and return at the edge where it is taken
  task automatic offer_item(imu_item_t it);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= it.cmd;
    stamp_i     <= it.stamp;
    end_stamp_i <= it.end_stamp;
    {gyro_z_i, gyro_y_i, gyro_x_i, accel_z_i, accel_y_i, accel_x_i} <= it.ax;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    predict_segment(it);
    if (it.typed && result_q.size() > 0) result_q[$].status = it.typed_status;
  endtask

  // sender pause: nothing offered until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() > 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [GapW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CAPACITY) cap_reg = val[CapW-1:0];
    else gap_reg = val;
  endtask

  // well-formed adds and selects with some noise
  function automatic imu_item_t rand_item();
    imu_item_t it;
    int unsigned r;
    logic [TsW-1:0] lo, hi, span;
    it.typed = 1'b0;
    it.typed_status = ST_ACCEPTED;
    it.ax = rand_axes();
    it.end_stamp = TsW'({$urandom, $urandom});
    r = $urandom_range(99);
    lo = (ring_fill > 0) ? ring_stamp[ring_slot(0)] : '0;
    hi = (ring_fill > 0) ? newest_stamp() : TsW'($urandom_range(5000));
    if (r < 55) begin
      it.cmd = CMD_ADD;
      r = $urandom_range(99);
      if (r < 6 && ring_fill > 0) it.stamp = hi;
      else if (r < 11) it.stamp = hi - TsW'($urandom_range(3000, 1));
      else if (r < 16) it.stamp = hi + TsW'(gap_reg) + TsW'($urandom_range(2000, 1));
      else if (gap_reg == 0) it.stamp = hi + 1;
      else it.stamp = hi + TsW'($urandom_range((gap_reg > 2000) ? 2000 : gap_reg, 1));
    end else if (r < 93) begin
      it.cmd = CMD_SELECT;
      span = hi - lo;
      r = $urandom_range(99);
      it.stamp = lo + rand_below(span);
      it.end_stamp = it.stamp + 1 + rand_below(hi - it.stamp);
      if (r < 8) it.stamp = lo - TsW'($urandom_range(500, 1));
      else if (r < 16) it.end_stamp = hi + TsW'($urandom_range(500, 1));
      else if (r < 22) it.end_stamp = it.stamp - TsW'($urandom_range(3));
    end else if (r < 97) begin
      it.cmd = CMD_RESET;
      it.stamp = TsW'({$urandom, $urandom});
    end else begin
      it.cmd = CMD_UNUSED;
      it.stamp = TsW'({$urandom, $urandom});
    end
    return it;
  endfunction

  // directed rows; typed status only where it is plain from the case
  function automatic imu_item_t row(cmd_e c, logic [TsW-1:0] t, logic [TsW-1:0] te,
                                    axes_t ax, bit typed, status_e st);
    imu_item_t it;
    it.cmd = c;
    it.stamp = t;
    it.end_stamp = te;
    it.ax = ax;
    it.typed = typed;
    it.typed_status = st;
    return it;
  endfunction

  initial begin
    imu_item_t plan[$];
    axes_t lo_ax, hi_ax;
    logic [CapW-1:0] caps[6];
    logic [GapW-1:0] gaps[6];
    ring_oldest = 0;
    ring_fill = 0;
    seg_count = '0;
    cap_reg = CapRst;
    gap_reg = GapRst;
    hold_req = 1'b0;
    for (int i = 0; i < NumAx; i++) begin
      lo_ax[i] = 16'h8000;
      hi_ax[i] = 16'h7fff;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table at the reset settings
    plan = {plan, row(CMD_SELECT, 10, 20, '0, 1, ST_WAITING)};        // empty ring
    plan = {plan, row(CMD_ADD, 1000, 0, lo_ax, 1, ST_ACCEPTED)};      // first sample
    plan = {plan, row(CMD_ADD, 1000, 0, hi_ax, 1, ST_DUPLICATE)};
    plan = {plan, row(CMD_ADD, 2000, 0, hi_ax, 1, ST_ACCEPTED)};
    plan = {plan, row(CMD_ADD, 3000, 0, lo_ax, 1, ST_ACCEPTED)};
    plan = {plan, row(CMD_SELECT, 1500, 2500, '0, 0, ST_READY)};      // blended ends
    plan = {plan, row(CMD_SELECT, 1000, 3000, '0, 0, ST_READY)};      // ends on samples
    plan = {plan, row(CMD_SELECT, 2000, 1000, '0, 1, ST_INVALID)};    // end before start
    plan = {plan, row(CMD_SELECT, 2000, 2000, '0, 1, ST_INVALID)};    // empty interval
    plan = {plan, row(CMD_SELECT, 500, 2500, '0, 1, ST_GONE)};        // start too old
    plan = {plan, row(CMD_SELECT, 1500, 9000, '0, 1, ST_WAITING)};    // end not yet seen
    plan = {plan, row(CMD_ADD, 2500, 0, rand_axes(), 1, ST_REVERSAL)};
    plan = {plan, row(CMD_ADD, 52500, 0, rand_axes(), 1, ST_ACCEPTED)}; // step at max_gap
    plan = {plan, row(CMD_ADD, 102501, 0, rand_axes(), 1, ST_GAP)};   // one past max_gap
    plan = {plan, row(CMD_UNUSED, 5, 6, '0, 1, ST_INVALID)};
    plan = {plan, row(CMD_RESET, 0, 0, '0, 1, ST_RESET_DONE)};
    plan = {plan, row(CMD_ADD, '1, '1, hi_ax, 1, ST_ACCEPTED)};       // top stamp
    plan = {plan, row(CMD_SELECT, 0, '1, '0, 1, ST_GONE)};
    plan = {plan, row(CMD_ADD, 0, 0, lo_ax, 1, ST_REVERSAL)};
    plan = {plan, row(CMD_ADD, 100, 0, rand_axes(), 0, ST_ACCEPTED)};
    plan = {plan, row(CMD_ADD, 200, 0, rand_axes(), 0, ST_ACCEPTED)};
    plan = {plan, row(CMD_ADD, 300, 0, rand_axes(), 0, ST_ACCEPTED)};
    plan = {plan, row(CMD_SELECT, 0, 300, '0, 0, ST_READY)};          // starts at oldest
    plan = {plan, row(CMD_SELECT, 50, 250, '0, 0, ST_READY)};
    foreach (plan[i]) offer_item(plan[i]);
    drain();

    // register settings per random phase, extremes included
    caps = '{6'd32, 6'd1, 6'd0, 6'd5, 6'd63, 6'd3};
    gaps = '{32'd50000, 32'd1, 32'd0, 32'd800, 32'hffff_ffff, 32'd3000};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CAPACITY, GapW'(caps[ph]));
      write_reg(REG_MAX_GAP, gaps[ph]);
      // long receiver hold-off in one phase so the input backs up
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 52; n++) offer_item(rand_item());
      drain();
    end

    in_valid_i <= 1'b0;
    while (result_q.size() > 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
